// ----- sv/fppe_pkg.sv -----
// Shared types and constants for the fixed-point polynomial evaluator.
package fppe_pkg;

   localparam int unsigned COEFF_REGS = 6;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned ADDR_W     = 5;

   localparam logic [4:0] Q_FORMAT_RESET   = 5'd16;
   localparam logic [2:0] TERM_COUNT_RESET = 3'd0;

   typedef enum logic [2:0] {
      REG_Q_FORMAT   = 3'd0,
      REG_TERM_COUNT = 3'd1,
      REG_COEFF_0    = 3'd2,
      REG_COEFF_1    = 3'd3,
      REG_COEFF_2    = 3'd4,
      REG_COEFF_3    = 3'd5,
      REG_COEFF_4    = 3'd6,
      REG_COEFF_5    = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [4:0]                         q_format;
      logic [2:0]                         term_count;
      logic [COEFF_REGS-1:0][DATA_W-1:0]  coeff;
   } cfg_type;

   typedef struct packed {
      logic [4:0]        q_format;
      logic              term_on;
      logic [DATA_W-1:0] coeff;
   } cell_cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] sample;
      logic [DATA_W-1:0] power;
      logic [DATA_W-1:0] sum;
   } beat_type;

endpackage

// ----- sv/fixed_point_polynomial_eval_core.sv -----
// Top level of the fixed-point polynomial evaluator: registers and cell chain.
//
// Evaluates sum over k < term_count (at most MAX_TERMS) of (coeff_k * x^k) >> q_format on each
// signed 32-bit sample, with wrapping 32-bit arithmetic. One sample is taken
// every cycle while the chain is not stalled; the result comes from the chain of
// MAX_TERMS cells, each of two register stages: two 32x32 multipliers, then
// a shift and add. Stalls on the result side back up only as far as the first
// empty stage, so the input keeps taking beats while bubbles remain in the
// chain. Configuration must be written through the APB port only while no
// sample is in flight; the block itself does not enforce this.
module fixed_point_polynomial_eval_core #(
   parameter int unsigned MAX_TERMS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [31:0]            req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_poly_value,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fppe_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [fppe_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [fppe_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int unsigned DEPTH  = 2 * MAX_TERMS;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

   fppe_pkg::cfg_type         cfg;
   fppe_pkg::beat_type        beat     [MAX_TERMS+1];
   logic                      valid    [MAX_TERMS+1];
   logic                      ready    [MAX_TERMS+1];
   logic [2:0]                terms_used;
   logic [CNT_W-1:0]          inflight_ff;
   logic [CNT_W-1:0]          inflight_in;

   fppe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign terms_used = (cfg.term_count > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : cfg.term_count;

   assign valid[0]       = req_valid;
   assign req_ready      = ready[0];
   assign beat[0].sample = req_sample;
   assign beat[0].power  = 32'd1 << cfg.q_format;
   assign beat[0].sum    = '0;

   for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
      fppe_pkg::cell_cfg_type cell_cfg;

      assign cell_cfg.q_format = cfg.q_format;
      assign cell_cfg.term_on  = 3'(k) < terms_used;
      assign cell_cfg.coeff    = cfg.coeff[k];

      fppe_cell #(
         .LEAD (k == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_cfg  (cell_cfg),
         .in_valid  (valid[k]),
         .in_ready  (ready[k]),
         .in_beat   (beat[k]),
         .out_valid (valid[k+1]),
         .out_ready (ready[k+1]),
         .out_beat  (beat[k+1])
      );
   end

   assign rsp_valid      = valid[MAX_TERMS];
   assign ready[MAX_TERMS] = rsp_ready;
   assign rsp_poly_value = $signed(beat[MAX_TERMS].sum);

   always_comb begin
      inflight_in = inflight_ff;
      if (req_valid && req_ready) begin
         inflight_in = inflight_in + CNT_W'(1);
      end
      if (rsp_valid && rsp_ready) begin
         inflight_in = inflight_in - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled while result slot is empty");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CNT_W'(DEPTH))
      else $error("more beats in flight than chain stages");

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("result beat with no accepted sample");

endmodule

// ----- sv/fppe_csr.sv -----
// APB register file holding the Q format, term count and coefficients.
module fppe_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fppe_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [fppe_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [fppe_pkg::DATA_W-1:0]       csr_prdata,
   output logic                              csr_pready,
   output fppe_pkg::cfg_type                 cfg
);

   logic [4:0]                      q_format_ff;
   logic [2:0]                      term_count_ff;
   logic [fppe_pkg::DATA_W-1:0]     coeff_ff [fppe_pkg::COEFF_REGS];
   fppe_pkg::reg_index_type         index;
   logic                            write_en;
   logic [2:0]                      coeff_sel;

   assign index     = fppe_pkg::reg_index_type'(csr_paddr[4:2]);
   assign write_en  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign coeff_sel = 3'(index - fppe_pkg::REG_COEFF_0);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_format_ff   <= fppe_pkg::Q_FORMAT_RESET;
         term_count_ff <= fppe_pkg::TERM_COUNT_RESET;
         for (int i = 0; i < int'(fppe_pkg::COEFF_REGS); i++) begin
            coeff_ff[i] <= '0;
         end
      end else if (write_en) begin
         case (index)
            fppe_pkg::REG_Q_FORMAT: begin
               q_format_ff <= csr_pwdata[4:0];
            end
            fppe_pkg::REG_TERM_COUNT: begin
               term_count_ff <= csr_pwdata[2:0];
            end
            default: begin
               if (index inside {[fppe_pkg::REG_COEFF_0:fppe_pkg::REG_COEFF_5]}) begin
                  coeff_ff[coeff_sel] <= csr_pwdata;
               end
            end
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (index)
         fppe_pkg::REG_Q_FORMAT: begin
            csr_prdata = {27'd0, q_format_ff};
         end
         fppe_pkg::REG_TERM_COUNT: begin
            csr_prdata = {29'd0, term_count_ff};
         end
         default: begin
            csr_prdata = coeff_ff[coeff_sel];
         end
      endcase
   end

   always_comb begin
      cfg.q_format   = q_format_ff;
      cfg.term_count = term_count_ff;
      for (int i = 0; i < int'(fppe_pkg::COEFF_REGS); i++) begin
         cfg.coeff[i] = coeff_ff[i];
      end
   end

endmodule

// ----- sv/fppe_cell.sv -----
// One polynomial cell: adds its term to the running sum and forms the next power.
module fppe_cell #(
   parameter bit LEAD = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fppe_pkg::cell_cfg_type cell_cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  fppe_pkg::beat_type     in_beat,
   output logic                   out_valid,
   input  logic                   out_ready,
   output fppe_pkg::beat_type     out_beat
);

   logic                      a_valid_ff;
   logic signed [63:0]        term_prod_ff;
   logic signed [63:0]        term_prod_in;
   logic signed [63:0]        power_prod_ff;
   logic signed [63:0]        power_prod_in;
   logic [31:0]               a_sample_ff;
   logic [31:0]               a_sum_ff;
   logic                      b_valid_ff;
   fppe_pkg::beat_type        b_beat_ff;
   fppe_pkg::beat_type        b_beat_in;
   logic signed [31:0]        power_s;
   logic signed [31:0]        sample_s;
   logic signed [31:0]        coeff_s;
   logic signed [63:0]        term_shift;
   logic signed [63:0]        power_shift;
   logic                      en_a;
   logic                      en_b;

   assign en_b     = !b_valid_ff || out_ready;
   assign en_a     = !a_valid_ff || en_b;
   assign in_ready = en_a;

   assign power_s  = $signed(in_beat.power);
   assign sample_s = $signed(in_beat.sample);
   assign coeff_s  = $signed(cell_cfg.coeff);

   assign term_prod_in  = power_s * coeff_s;
   assign power_prod_in = power_s * sample_s;

   assign term_shift  = term_prod_ff >>> cell_cfg.q_format;
   assign power_shift = power_prod_ff >>> cell_cfg.q_format;

   always_comb begin
      b_beat_in.sample = a_sample_ff;
      b_beat_in.power  = LEAD ? a_sample_ff : power_shift[31:0];
      b_beat_in.sum    = cell_cfg.term_on ? a_sum_ff + term_shift[31:0] : a_sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_valid_ff <= in_valid;
         end
         if (en_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         term_prod_ff  <= term_prod_in;
         power_prod_ff <= power_prod_in;
         a_sample_ff   <= in_beat.sample;
         a_sum_ff      <= in_beat.sum;
      end
      if (en_b) begin
         b_beat_ff <= b_beat_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_beat  = b_beat_ff;

endmodule

// ----- tb/fppe_result_checker.sv -----
// Result checker for the polynomial evaluator: tracks CSR writes, predicts and compares results.
module fppe_result_checker #(
   parameter int unsigned MAX_TERMS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [31:0]                   req_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [31:0]                   rsp_poly_value,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fppe_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [fppe_pkg::DATA_W-1:0]   csr_pwdata,
   input  logic [fppe_pkg::DATA_W-1:0]   csr_prdata,
   input  logic                          csr_pready,
   output int                            fail_count,
   output int                            outstanding,
   output int                            compared
);

   logic [4:0]  q_fmt;
   logic [2:0]  n_terms;
   logic [31:0] coeff [fppe_pkg::COEFF_REGS];
   logic [31:0] poly_q [$];

   function automatic logic [31:0] poly_eval(input logic [31:0] x);
      longint      xs;
      longint      pw;
      longint      prod;
      logic [31:0] power;
      logic [31:0] acc;
      int          n;
      int          k;
      n = (n_terms > MAX_TERMS) ? MAX_TERMS : n_terms;
      xs = $signed(x);
      acc = '0;
      power = '0;
      for (k = 0; k < n; k++) begin
         if (k == 0) begin
            power = 32'd1 << q_fmt;
         end else if (k == 1) begin
            power = x;
         end else begin
            pw = $signed(power);
            prod = pw * xs;
            power = 32'(prod >>> q_fmt);
         end
         pw = $signed(power);
         prod = pw * longint'($signed(coeff[k]));
         acc = acc + 32'(prod >>> q_fmt);
      end
      return acc;
   endfunction

   function automatic logic [31:0] reg_value(input fppe_pkg::reg_index_type idx);
      case (idx)
         fppe_pkg::REG_Q_FORMAT:   return {27'd0, q_fmt};
         fppe_pkg::REG_TERM_COUNT: return {29'd0, n_terms};
         default:                  return coeff[idx - fppe_pkg::REG_COEFF_0];
      endcase
   endfunction

   initial begin
      fail_count = 0;
      compared = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin : watch
      logic [31:0]             want;
      fppe_pkg::reg_index_type idx;
      if (reset) begin
         q_fmt <= fppe_pkg::Q_FORMAT_RESET;
         n_terms <= fppe_pkg::TERM_COUNT_RESET;
         for (int i = 0; i < int'(fppe_pkg::COEFF_REGS); i++) begin
            coeff[i] <= '0;
         end
         poly_q.delete();
         outstanding <= 0;
      end else begin
         idx = fppe_pkg::reg_index_type'(csr_paddr[4:2]);
         if (csr_psel && csr_penable && csr_pready && csr_pwrite) begin
            case (idx)
               fppe_pkg::REG_Q_FORMAT:   q_fmt <= csr_pwdata[4:0];
               fppe_pkg::REG_TERM_COUNT: n_terms <= csr_pwdata[2:0];
               default:                  coeff[idx - fppe_pkg::REG_COEFF_0] <= csr_pwdata;
            endcase
         end
         if (csr_psel && csr_penable && csr_pready && !csr_pwrite) begin
            if (csr_prdata !== reg_value(idx)) begin
               $error("csr_prdata %s: expected 0x%08h, got 0x%08h",
                      idx.name(), reg_value(idx), csr_prdata);
               fail_count++;
            end
         end
         if (req_valid && req_ready) begin
            poly_q.push_back(poly_eval(req_sample));
         end
         if (rsp_valid && rsp_ready) begin
            if (poly_q.size() == 0) begin
               $error("poly_value: unexpected beat %0d with nothing outstanding",
                      $signed(rsp_poly_value));
               fail_count++;
            end else begin
               want = poly_q.pop_front();
               compared++;
               if (rsp_poly_value !== want) begin
                  $error("poly_value: expected %0d, got %0d",
                         $signed(want), $signed(rsp_poly_value));
                  fail_count++;
               end
            end
         end
         outstanding <= poly_q.size();
      end
   end

endmodule

// ----- tb/testbench.sv -----
// Top of the polynomial evaluator testbench: clock, reset, stimulus and verdict.
module testbench;

   localparam int unsigned MAX_TERMS = 6;
   localparam int          ITEMS     = 1500;
   localparam int          LIMIT     = 400000;

   logic                          clock;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   logic signed [31:0]            req_sample  = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   logic signed [31:0]            rsp_poly_value;
   logic                          csr_psel    = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite  = 1'b0;
   logic [fppe_pkg::ADDR_W-1:0]   csr_paddr   = '0;
   logic [fppe_pkg::DATA_W-1:0]   csr_pwdata  = '0;
   logic [fppe_pkg::DATA_W-1:0]   csr_prdata;
   logic                          csr_pready;

   int          fail_count;
   int          outstanding;
   int          compared;
   int          sent = 0;
   int          settings_count = 0;
   bit          calm = 1'b0;
   logic [4:0]  q_set;
   logic [2:0]  tc_set;
   logic [31:0] coeff_set [fppe_pkg::COEFF_REGS];

   fixed_point_polynomial_eval_core #(.MAX_TERMS(MAX_TERMS)) dut (.*);

   fppe_result_checker #(.MAX_TERMS(MAX_TERMS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin : watchdog
      repeat (LIMIT) @(posedge clock);
      $error("timeout after %0d cycles with %0d results outstanding", LIMIT, outstanding);
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic [31:0] pick_value(input logic [4:0] q);
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0: v = $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0:       v = 32'h7FFF_FFFF;
               1:       v = 32'h8000_0000;
               2:       v = '0;
               3:       v = 32'd1 << q;
               default: v = -(32'd1 << q);
            endcase
         end
         default: begin
            v = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   task automatic send_sample(input logic [31:0] x);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= x;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic csr_access(input logic write, input fppe_pkg::reg_index_type idx,
                             input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Drain the pipeline, write every register, then read them all back.
   task automatic apply_settings;
      fppe_pkg::reg_index_type idx;
      drain();
      csr_access(1'b1, fppe_pkg::REG_Q_FORMAT, {27'd0, q_set});
      csr_access(1'b1, fppe_pkg::REG_TERM_COUNT, {29'd0, tc_set});
      for (int i = 0; i < int'(fppe_pkg::COEFF_REGS); i++) begin
         csr_access(1'b1, fppe_pkg::reg_index_type'(fppe_pkg::REG_COEFF_0 + i), coeff_set[i]);
      end
      idx = idx.first();
      repeat (idx.num()) begin
         csr_access(1'b0, idx, '0);
         idx = idx.next();
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      settings_count++;
   endtask

   initial begin : stimulus
      int len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero terms
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);

      q_set = 5'd16;
      tc_set = 3'd6;
      coeff_set[0] = 32'h7FFF_FFFF;
      coeff_set[1] = 32'h8000_0000;
      coeff_set[2] = 32'h0001_0000;
      coeff_set[3] = 32'hFFFF_0000;
      coeff_set[4] = 32'h0001_8000;
      coeff_set[5] = 32'hFFFF_FFFF;
      apply_settings();
      send_sample(32'h0000_0000);
      send_sample(32'h0001_0000);
      send_sample(32'hFFFF_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0001);
      send_sample(32'hFFFF_FFFF);

      // term count above the cell count clamps
      tc_set = 3'd7;
      apply_settings();
      send_sample(32'h0002_0000);
      send_sample(32'h8000_0000);

      // shift of 31 makes the zeroth power negative
      q_set = 5'd31;
      tc_set = 3'd6;
      apply_settings();
      send_sample(32'h8000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF);

      q_set = 5'd0;
      apply_settings();
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0003);
      send_sample(32'hFFFF_FFFE);

      q_set = 5'd30;
      tc_set = 3'd1;
      apply_settings();
      send_sample(32'h4000_0000);
      send_sample(32'h8000_0000);

      while (sent < ITEMS + 20) begin
         case ($urandom_range(0, 5))
            0:       q_set = 5'd0;
            1:       q_set = 5'd30;
            2:       q_set = 5'd31;
            default: q_set = 5'($urandom_range(0, 31));
         endcase
         tc_set = 3'($urandom_range(0, 7));
         for (int i = 0; i < int'(fppe_pkg::COEFF_REGS); i++) begin
            coeff_set[i] = pick_value(q_set);
         end
         apply_settings();
         calm = ($urandom_range(0, 3) == 0);
         len = $urandom_range(20, 120);
         repeat (len) send_sample(pick_value(q_set));
         calm = 1'b0;
      end

      drain();
      repeat (2 * MAX_TERMS + 4) @(posedge clock);
      $display("testbench: %0d samples over %0d register settings, %0d results compared",
               sent, settings_count, compared);
      $display("testbench: q_format 0 to 31, term_count 0 to 7, stalls on both channels");
      if (fail_count == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
